@@ hdl/nsd_pkg.sv @@
`timescale 1ns / 1ps
package nsd_pkg;

  localparam int LANES    = 5;
  localparam int OTH_N    = LANES - 1;
  localparam int ORD_W    = 3;
  localparam int OFF_W    = 16;
  localparam int SMP_W    = 32;
  localparam int DIF_W    = OFF_W;       // |x_i - x_j| <= 65535
  localparam int PP_W     = 2 * OFF_W;
  localparam int E_W      = PP_W + 3;    // signed sum of six products
  localparam int EMAG_W   = PP_W + 1;    // |e| < 6 * 2^30
  localparam int DEN_W    = 4 * DIF_W;
  localparam int PROD_W   = 64;          // |e| * |v| < 1.5 * 2^63
  localparam int FRAC_SH  = 17;          // times 2 * 2^16
  localparam int NUM_W    = PROD_W + FRAC_SH;
  localparam int QR_W     = NUM_W + 1;   // quotient after rounding
  localparam int TERM_W   = QR_W + 1;
  localparam int SUM_W    = TERM_W + 3;
  localparam int RES_W    = 48;
  localparam int FRONT_LAT = 3;
  localparam int LANE_LAT = FRONT_LAT + NUM_W + 1;

  localparam logic [ORD_W-1:0] ORD_2 = 3'd2;
  localparam logic [ORD_W-1:0] ORD_3 = 3'd3;
  localparam logic [ORD_W-1:0] ORD_4 = 3'd4;

  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (RES_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (RES_W - 1));

  typedef struct packed {
    logic [LANES-1:0] used;
    logic             ord_err;
    logic             degen;
    logic             zero;
  } nsd_ctrl_t;

endpackage

@@ hdl/nsd_div.sv @@
`timescale 1ns / 1ps
// Bit-per-stage restoring divider with round half away from zero and sign.
module nsd_div import nsd_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [NUM_W-1:0]         num,
  input  logic [DEN_W-1:0]         den,
  input  logic                     neg,
  output logic signed [TERM_W-1:0] term
);

  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] sh_r  [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic             neg_r [NUM_W];
  logic [DEN_W-1:0] rem_nxt [NUM_W];
  logic [NUM_W-1:0] sh_nxt  [NUM_W];
  logic signed [TERM_W-1:0] term_r;

  genvar s;
  generate
    for (s = 0; s < NUM_W; s++) begin : g_stage
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] sh_in;
      logic [DEN_W-1:0] den_in;
      logic             neg_in;
      logic [DEN_W:0]   tmp;
      logic             ge;
      if (s == 0) begin : g_first
        assign rem_in = '0;
        assign sh_in  = num;
        assign den_in = den;
        assign neg_in = neg;
      end else begin : g_next
        assign rem_in = rem_r[s-1];
        assign sh_in  = sh_r[s-1];
        assign den_in = den_r[s-1];
        assign neg_in = neg_r[s-1];
      end
      always_comb begin
        tmp = {rem_in, sh_in[NUM_W-1]};
        ge  = tmp >= {1'b0, den_in};
        rem_nxt[s] = ge ? DEN_W'(tmp - {1'b0, den_in}) : tmp[DEN_W-1:0];
        sh_nxt[s]  = {sh_in[NUM_W-2:0], ge};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt[s];
          sh_r[s]  <= sh_nxt[s];
          den_r[s] <= den_in;
          neg_r[s] <= neg_in;
        end
      end
    end
  endgenerate

  logic [DEN_W:0]  twice;
  logic [QR_W-1:0] qr;
  logic signed [TERM_W-1:0] term_nxt;

  always_comb begin
    twice = {rem_r[NUM_W-1], 1'b0};
    qr    = QR_W'(sh_r[NUM_W-1]) + QR_W'(twice >= {1'b0, den_r[NUM_W-1]});
    term_nxt = neg_r[NUM_W-1] ? -$signed(TERM_W'(qr)) : $signed(TERM_W'(qr));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

@@ hdl/nsd_lane.sv @@
`timescale 1ns / 1ps
// One stencil coefficient times its sample, rounded to Q.16 units.
module nsd_lane import nsd_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ORD_W-1:0]        order,
  input  logic signed [OFF_W-1:0] x_self,
  input  logic signed [OFF_W-1:0] x_oth [OTH_N],
  input  logic signed [SMP_W-1:0] smp,
  output logic signed [TERM_W-1:0] term
);

  // stage 1: differences, pair products, sample magnitude
  logic [DIF_W-1:0]        adif_r [OTH_N];
  logic                    dneg_r;
  logic signed [PP_W-1:0]  pp_r [6];
  logic signed [OFF_W+1:0] s3_r;
  logic [SMP_W-1:0]        vmag_r;
  logic                    vneg_r;
  logic [ORD_W-1:0]        ord_r;

  logic [DIF_W-1:0]        adif_nxt [OTH_N];
  logic                    dneg_nxt;

  always_comb begin
    logic signed [OFF_W:0] d;
    dneg_nxt = 1'b0;
    for (int k = 0; k < OTH_N; k++) begin
      d = {x_self[OFF_W-1], x_self} - {x_oth[k][OFF_W-1], x_oth[k]};
      if (k < int'(order)) begin
        adif_nxt[k] = d[OFF_W] ? DIF_W'(-d) : DIF_W'(d);
        dneg_nxt    = dneg_nxt ^ d[OFF_W];
      end else begin
        adif_nxt[k] = DIF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adif_r <= adif_nxt;
      dneg_r <= dneg_nxt;
      pp_r[0] <= x_oth[0] * x_oth[1];
      pp_r[1] <= x_oth[0] * x_oth[2];
      pp_r[2] <= x_oth[0] * x_oth[3];
      pp_r[3] <= x_oth[1] * x_oth[2];
      pp_r[4] <= x_oth[1] * x_oth[3];
      pp_r[5] <= x_oth[2] * x_oth[3];
      s3_r   <= (OFF_W+2)'(x_oth[0]) + (OFF_W+2)'(x_oth[1]) + (OFF_W+2)'(x_oth[2]);
      vmag_r <= smp[SMP_W-1] ? SMP_W'(-smp) : SMP_W'(smp);
      vneg_r <= smp[SMP_W-1];
      ord_r  <= order;
    end
  end

  // stage 2: half products of the denominator, symmetric sum
  logic [2*DIF_W-1:0] p01_r, p23_r;
  logic [EMAG_W-1:0]  emag_r;
  logic [SMP_W-1:0]   vmag2_r;
  logic               neg2_r;
  logic signed [E_W-1:0] e_nxt;

  always_comb begin
    unique case (ord_r)
      ORD_4:   e_nxt = E_W'(pp_r[0]) + E_W'(pp_r[1]) + E_W'(pp_r[2])
                     + E_W'(pp_r[3]) + E_W'(pp_r[4]) + E_W'(pp_r[5]);
      ORD_3:   e_nxt = E_W'(s3_r);
      default: e_nxt = E_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p01_r   <= adif_r[0] * adif_r[1];
      p23_r   <= adif_r[2] * adif_r[3];
      emag_r  <= e_nxt[E_W-1] ? EMAG_W'(-e_nxt) : EMAG_W'(e_nxt);
      neg2_r  <= (ord_r == ORD_3) ^ e_nxt[E_W-1] ^ vneg_r ^ dneg_r;
      vmag2_r <= vmag_r;
    end
  end

  // stage 3: denominator and numerator magnitude
  logic [DEN_W-1:0]  pmag_r;
  logic [PROD_W-1:0] prod_r;
  logic              neg3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pmag_r <= DEN_W'(p01_r * p23_r);
      prod_r <= PROD_W'(emag_r * vmag2_r);
      neg3_r <= neg2_r;
    end
  end

  nsd_div u_div (
    .clk  (clk),
    .en   (en),
    .num  ({prod_r, FRAC_SH'(0)}),
    .den  (pmag_r),
    .neg  (neg3_r),
    .term (term)
  );

endmodule

@@ hdl/nonuniform_second_derivative.sv @@
`timescale 1ns / 1ps
// Second derivative at the origin from a non-uniform stencil of 3 to 5 points
// (order 2, 3 or 4). Takes one item per cycle while the pipe is not stalled and
// delivers one result per item: five lanes run in parallel, one per stencil
// point, each with coefficient setup stages, an 81-stage bit-per-stage
// divider and a rounding stage; a final stage sums the lanes, saturates to
// Q32.16 and holds the result in the output register. Backpressure on out_
// stalls the whole pipe; in_tready is high whenever the output register is
// empty or being drained. Orders 0/1 yield zero, 5..7 yield order_error,
// coincident used points yield degenerate, all with a zero result.
module nonuniform_second_derivative import nsd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // order[2:0], offset_0..offset_4 [82:3], sample_0..sample_4 [242:83], pad
  input  logic [247:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // second_derivative[47:0]
  output logic [47:0]  out_tdata,
  // order_error[0], degenerate[1], saturated[2]
  output logic [2:0]   out_tuser
);

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // unpack
  logic [ORD_W-1:0]        order;
  logic signed [OFF_W-1:0] off [LANES];
  logic signed [SMP_W-1:0] smp [LANES];

  assign order = in_tdata[ORD_W-1:0];
  genvar g;
  generate
    for (g = 0; g < LANES; g++) begin : g_unpack
      assign off[g] = in_tdata[ORD_W + g*OFF_W +: OFF_W];
      assign smp[g] = in_tdata[ORD_W + LANES*OFF_W + g*SMP_W +: SMP_W];
    end
  endgenerate

  // item-level flags, worked out at the input
  nsd_ctrl_t ctrl_in;
  always_comb begin
    logic any3, any4, any5;
    any3 = (off[0] == off[1]) || (off[0] == off[2]) || (off[1] == off[2]);
    any4 = (off[0] == off[3]) || (off[1] == off[3]) || (off[2] == off[3]);
    any5 = (off[0] == off[4]) || (off[1] == off[4]) || (off[2] == off[4])
           || (off[3] == off[4]);
    ctrl_in.ord_err = order > ORD_4;
    ctrl_in.zero    = order < ORD_2;
    for (int i = 0; i < LANES; i++) begin
      ctrl_in.used[i] = i <= int'(order);
    end
    ctrl_in.degen = !ctrl_in.ord_err && !ctrl_in.zero &&
                    (any3 || (order >= ORD_3 && any4) || (order == ORD_4 && any5));
  end

  // lanes: lane i sees its own point and the others in ascending order
  logic signed [TERM_W-1:0] term [LANES];
  generate
    for (g = 0; g < LANES; g++) begin : g_lane
      logic signed [OFF_W-1:0] oth [OTH_N];
      for (genvar k = 0; k < OTH_N; k++) begin : g_oth
        assign oth[k] = (k < g) ? off[k] : off[k+1];
      end
      nsd_lane u_lane (
        .clk    (clk),
        .en     (en),
        .order  (order),
        .x_self (off[g]),
        .x_oth  (oth),
        .smp    (smp[g]),
        .term   (term[g])
      );
    end
  endgenerate

  // control line matching lane latency
  nsd_ctrl_t ctrl_r [LANE_LAT];
  logic      vld_r  [LANE_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r[0] <= ctrl_in;
      for (int i = 1; i < LANE_LAT; i++) begin
        ctrl_r[i] <= ctrl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < LANE_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // merge: sum lanes, saturate
  nsd_ctrl_t ctl;
  logic signed [SUM_W-1:0] sum;
  logic [RES_W-1:0] res_nxt;
  logic             sat_nxt;

  assign ctl = ctrl_r[LANE_LAT-1];

  always_comb begin
    sum = '0;
    for (int i = 0; i < LANES; i++) begin
      if (ctl.used[i]) begin
        sum = sum + SUM_W'(term[i]);
      end
    end
    sat_nxt = 1'b0;
    res_nxt = '0;
    if (!ctl.ord_err && !ctl.zero && !ctl.degen) begin
      if (sum > SAT_HI) begin
        sat_nxt = 1'b1;
        res_nxt = SAT_HI[RES_W-1:0];
      end else if (sum < SAT_LO) begin
        sat_nxt = 1'b1;
        res_nxt = SAT_LO[RES_W-1:0];
      end else begin
        res_nxt = sum[RES_W-1:0];
      end
    end
  end

  logic            out_valid_r;
  logic [RES_W-1:0] res_r;
  logic [2:0]       flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r   <= res_nxt;
      flags_r <= {sat_nxt, ctl.degen, ctl.ord_err};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;
  assign out_tuser  = flags_r;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[1]) |-> out_tdata == '0)
    else $error("flagged result not zero");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tuser) <= 1)
    else $error("more than one flag set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule
